>>> rtl/core/tsb_pkg.sv
package tsb_pkg;

  localparam int DEF_SLOTS    = 16;
  localparam int DEF_ID_WIDTH = 32;

  localparam int KIND_W = 2;
  localparam int TID_W  = 32;
  localparam int QUAD_W = 14;
  localparam int SQ_W   = 24;
  localparam int SD_W   = 16;
  localparam int ST_W   = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUADS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_ID  = 1'd1;

  localparam logic [QUAD_W-1:0] MAX_QUADS_RESET = 14'd10000;

  localparam logic [KIND_W-1:0] KIND_PLAIN    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXTURED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

  typedef struct packed {
    logic textured;
    logic commit;
    logic clear;
  } slot_ctl_t;

endpackage

>>> rtl/core/tsb_ifs.sv
interface tsb_req_if import tsb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  texture_id;

  modport source (output valid, kind, texture_id, input ready);
  modport sink   (input valid, kind, texture_id, output ready);
endinterface

interface tsb_res_if import tsb_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) ();
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FS_W   = $clog2(SLOTS + 1);

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              flushed;
  logic [QUAD_W-1:0] flush_quads;
  logic [FS_W-1:0]   flush_slots;
  logic [SQ_W-1:0]   scene_quad_total;
  logic [SD_W-1:0]   scene_draw_total;
  logic [ST_W-1:0]   scene_texture_total;

  modport source (output valid, slot, flushed, flush_quads, flush_slots, scene_quad_total,
                  scene_draw_total, scene_texture_total, input ready);
  modport sink   (input valid, slot, flushed, flush_quads, flush_slots, scene_quad_total,
                  scene_draw_total, scene_texture_total, output ready);
endinterface

>>> rtl/core/texture_slot_batcher.sv
// channel  | dir | payload
// ---------+-----+------------------------------------------------------------
// req      | in  | kind, texture_id
// res      | out | slot, flushed, flush_quads, flush_slots, scene totals
// cfg      | in  | cfg_wr_en, cfg_index, cfg_data (0 max_quads, 1 white_texture_id)
//
// one beat per cycle sustained while res is not stalled; a req beat reaches res through
// the input register, then lookup and counter update into the result register
// slot lookup is a combinational parallel compare against all used slots
// synchronous reset; slot table contents need no clearing, only the used count
// a stalled res beat holds the input register, and req.ready drops only then
module texture_slot_batcher import tsb_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int ID_WIDTH = DEF_ID_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tsb_req_if.sink               req,
  tsb_res_if.source             res
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FS_W   = $clog2(SLOTS + 1);

  logic [QUAD_W-1:0] max_quads;
  logic [TID_W-1:0]  white_texture_id;

  logic              in_vld;
  logic [KIND_W-1:0] in_kind;
  logic [TID_W-1:0]  in_tid;
  logic              advance;

  slot_ctl_t         ctl;
  logic [SLOT_W-1:0] tbl_slot;
  logic              inserted;
  logic [FS_W-1:0]   used_next;

  logic              st_flushed;
  logic [QUAD_W-1:0] st_fq;
  logic [FS_W-1:0]   st_fs;
  logic [SQ_W-1:0]   st_sq;
  logic [SD_W-1:0]   st_sd;
  logic [ST_W-1:0]   st_st;

  logic              out_vld;
  logic [SLOT_W-1:0] out_slot;
  logic              out_flushed;
  logic [QUAD_W-1:0] out_fq;
  logic [FS_W-1:0]   out_fs;
  logic [SQ_W-1:0]   out_sq;
  logic [SD_W-1:0]   out_sd;
  logic [ST_W-1:0]   out_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_quads        <= MAX_QUADS_RESET;
      white_texture_id <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MAX_QUADS: max_quads        <= cfg_data[QUAD_W-1:0];
        CFG_WHITE_ID:  white_texture_id <= cfg_data[TID_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = in_vld && (!out_vld || res.ready);
  assign req.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_kind <= req.kind;
      in_tid  <= req.texture_id;
    end
  end

  assign ctl.textured = in_kind == KIND_TEXTURED;
  assign ctl.commit   = advance;
  assign ctl.clear    = st_flushed;

  tsb_slot_table #(
    .SLOTS    (SLOTS),
    .ID_WIDTH (ID_WIDTH)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .key       (ID_WIDTH'(in_tid)),
    .white_key (ID_WIDTH'(white_texture_id)),
    .slot      (tbl_slot),
    .inserted  (inserted),
    .used_next (used_next)
  );

  tsb_batch_stats #(
    .SLOTS (SLOTS)
  ) u_stats (
    .clk                 (clk),
    .rst                 (rst),
    .step                (advance),
    .kind                (in_kind),
    .max_quads           (max_quads),
    .inserted            (inserted),
    .used_next           (used_next),
    .flushed             (st_flushed),
    .flush_quads         (st_fq),
    .flush_slots         (st_fs),
    .scene_quad_total    (st_sq),
    .scene_draw_total    (st_sd),
    .scene_texture_total (st_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_slot    <= ctl.textured ? tbl_slot : '0;
      out_flushed <= st_flushed;
      out_fq      <= st_fq;
      out_fs      <= st_fs;
      out_sq      <= st_sq;
      out_sd      <= st_sd;
      out_st      <= st_st;
    end
  end

  assign res.valid               = out_vld;
  assign res.slot                = out_slot;
  assign res.flushed             = out_flushed;
  assign res.flush_quads         = out_fq;
  assign res.flush_slots         = out_fs;
  assign res.scene_quad_total    = out_sq;
  assign res.scene_draw_total    = out_sd;
  assign res.scene_texture_total = out_st;

endmodule

>>> rtl/core/tsb_slot_table.sv
module tsb_slot_table import tsb_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int ID_WIDTH = DEF_ID_WIDTH,
  localparam int SLOT_W  = $clog2(SLOTS),
  localparam int FS_W    = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  slot_ctl_t           ctl,
  input  logic [ID_WIDTH-1:0] key,
  input  logic [ID_WIDTH-1:0] white_key,
  output logic [SLOT_W-1:0]   slot,
  output logic                inserted,
  output logic [FS_W-1:0]     used_next
);

  logic [ID_WIDTH-1:0] slot_ids [SLOTS];
  logic [FS_W-1:0]     slots_used;
  logic                hit;
  logic [SLOT_W-1:0]   hit_slot;
  logic                full;

  // lowest matching slot wins; white handle beats all
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = SLOTS - 1; i >= 1; i--) begin
      if (FS_W'(i) < slots_used && slot_ids[i] == key) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
    if (key == white_key) begin
      hit      = 1'b1;
      hit_slot = '0;
    end
  end

  assign full      = slots_used >= FS_W'(SLOTS);
  assign inserted  = ctl.textured && !hit && !full;
  assign slot      = hit ? hit_slot : (inserted ? slots_used[SLOT_W-1:0] : '0);
  assign used_next = inserted ? slots_used + FS_W'(1) : slots_used;

  always_ff @(posedge clk) begin
    if (ctl.commit && inserted) begin
      slot_ids[slots_used[SLOT_W-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used <= FS_W'(1);
    end else if (ctl.commit) begin
      slots_used <= ctl.clear ? FS_W'(1) : used_next;
    end
  end

endmodule

>>> rtl/core/tsb_batch_stats.sv
module tsb_batch_stats import tsb_pkg::*; #(
  parameter int SLOTS  = DEF_SLOTS,
  localparam int FS_W  = $clog2(SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [KIND_W-1:0] kind,
  input  logic [QUAD_W-1:0] max_quads,
  input  logic              inserted,
  input  logic [FS_W-1:0]   used_next,
  output logic              flushed,
  output logic [QUAD_W-1:0] flush_quads,
  output logic [FS_W-1:0]   flush_slots,
  output logic [SQ_W-1:0]   scene_quad_total,
  output logic [SD_W-1:0]   scene_draw_total,
  output logic [ST_W-1:0]   scene_texture_total
);

  logic [QUAD_W-1:0] batch_quads;
  logic [SQ_W-1:0]   scene_quads;
  logic [SD_W-1:0]   scene_draws;
  logic [ST_W-1:0]   scene_textures;

  logic              is_quad;
  logic              is_tex;
  logic              is_end;
  logic [QUAD_W-1:0] batch_inc;
  logic [QUAD_W-1:0] batch_next;
  logic [QUAD_W-1:0] batch_quads_next;

  assign is_quad = kind == KIND_PLAIN || kind == KIND_TEXTURED;
  assign is_tex  = kind == KIND_TEXTURED;
  assign is_end  = kind == KIND_END;

  assign batch_inc  = (batch_quads == '1) ? batch_quads : batch_quads + QUAD_W'(1);
  assign batch_next = is_quad ? batch_inc : batch_quads;

  assign flushed = (is_quad && (batch_inc >= max_quads ||
                               (is_tex && used_next >= FS_W'(SLOTS)))) ||
                   (is_end && (batch_quads != '0 || used_next > FS_W'(1)));

  assign flush_quads = flushed ? batch_next : '0;
  assign flush_slots = flushed ? used_next : '0;

  assign scene_quad_total = (is_quad && scene_quads != '1) ?
                            scene_quads + SQ_W'(1) : scene_quads;
  assign scene_draw_total = (flushed && scene_draws != '1) ?
                            scene_draws + SD_W'(1) : scene_draws;
  assign scene_texture_total = (inserted && scene_textures != '1) ?
                               scene_textures + ST_W'(1) : scene_textures;

  assign batch_quads_next = flushed ? '0 : batch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_quads    <= '0;
      scene_quads    <= '0;
      scene_draws    <= '0;
      scene_textures <= ST_W'(1);
    end else if (step) begin
      batch_quads <= batch_quads_next;
      if (is_end) begin
        scene_quads    <= '0;
        scene_draws    <= '0;
        scene_textures <= ST_W'(1);
      end else begin
        scene_quads    <= scene_quad_total;
        scene_draws    <= scene_draw_total;
        scene_textures <= scene_texture_total;
      end
    end
  end

endmodule

>>> rtl/core/tsb_checker.sv
module tsb_checker import tsb_pkg::*; #(
  parameter int SLOTS  = DEF_SLOTS,
  localparam int FS_W  = $clog2(SLOTS + 1)
) (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              flushed,
  input logic [QUAD_W-1:0] flush_quads,
  input logic [FS_W-1:0]   flush_slots,
  input logic [SD_W-1:0]   scene_draw_total,
  input logic [ST_W-1:0]   scene_texture_total
);

  // a stalled result beat stays up
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  // no flush means empty flush fields
  a_no_flush: assert property (@(posedge clk) disable iff (rst)
    res_valid && !flushed |-> flush_quads == '0 && flush_slots == '0)
    else $error("flush fields set without a flush");

  // a flush counts as a draw and always covers the white slot
  a_flush_draw: assert property (@(posedge clk) disable iff (rst)
    res_valid && flushed |-> scene_draw_total != '0 && flush_slots != '0)
    else $error("flush without draw count or slots");

  a_tex_total: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> scene_texture_total != '0)
    else $error("texture total lost the white texture");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind texture_slot_batcher tsb_checker #(
  .SLOTS (SLOTS)
) u_tsb_checker (
  .clk                 (clk),
  .rst                 (rst),
  .res_valid           (res.valid),
  .res_ready           (res.ready),
  .flushed             (res.flushed),
  .flush_quads         (res.flush_quads),
  .flush_slots         (res.flush_slots),
  .scene_draw_total    (res.scene_draw_total),
  .scene_texture_total (res.scene_texture_total)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tsb_pkg::*;

  localparam int SLOTS    = DEF_SLOTS;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int FS_W     = $clog2(SLOTS + 1);
  localparam int QUAD_MAX = (1 << QUAD_W) - 1;
  localparam int SQ_MAX   = (1 << SQ_W) - 1;
  localparam int SD_MAX   = (1 << SD_W) - 1;
  localparam int ST_MAX   = (1 << ST_W) - 1;
  localparam int POOL_N   = 20;
  localparam int QUIET_LIMIT = 3000;

  localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              flushed;
    logic [QUAD_W-1:0] flush_quads;
    logic [FS_W-1:0]   flush_slots;
    logic [SQ_W-1:0]   quad_total;
    logic [SD_W-1:0]   draw_total;
    logic [ST_W-1:0]   texture_total;
  } draw_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsb_req_if req_if ();
  tsb_res_if #(.SLOTS(SLOTS)) res_if ();

  texture_slot_batcher #(
    .SLOTS   (SLOTS),
    .ID_WIDTH(DEF_ID_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req_if),
    .res      (res_if)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mirror of the slot table, batch and scene counters
  logic [TID_W-1:0]  slot_handles [SLOTS];
  logic [QUAD_W-1:0] batch_limit;
  logic [TID_W-1:0]  white_handle;
  int unsigned       slots_in_use;
  int unsigned       batch_count;
  int unsigned       scene_quads;
  int unsigned       scene_draws;
  int unsigned       scene_textures;

  draw_result_t      pending_results [$];
  logic [TID_W-1:0]  handle_pool [POOL_N];

  int src_idle;
  int sink_stall;
  int hold_len;
  int hold_seq;
  int mismatches;
  int quiet_cycles;

  function automatic void close_batch(inout draw_result_t r);
    r.flushed     = 1'b1;
    r.flush_quads = batch_count[QUAD_W-1:0];
    r.flush_slots = slots_in_use[FS_W-1:0];
    batch_count   = 0;
    slots_in_use  = 1;
    if (scene_draws < SD_MAX) scene_draws++;
  endfunction

  function automatic draw_result_t predict_draw(input logic [KIND_W-1:0] kind,
                                                input logic [TID_W-1:0] tid);
    draw_result_t r;
    bit hit;
    int i;
    r = '0;
    if (kind == KIND_PLAIN || kind == KIND_TEXTURED) begin
      if (kind == KIND_TEXTURED) begin
        hit = (tid == white_handle);
        for (i = 1; i < slots_in_use; i++) begin
          if (!hit && slot_handles[i] == tid) begin
            hit    = 1'b1;
            r.slot = i[SLOT_W-1:0];
          end
        end
        if (!hit && slots_in_use < SLOTS) begin
          slot_handles[slots_in_use] = tid;
          r.slot = slots_in_use[SLOT_W-1:0];
          slots_in_use++;
          if (scene_textures < ST_MAX) scene_textures++;
        end
      end
      if (batch_count < QUAD_MAX) batch_count++;
      if (scene_quads < SQ_MAX) scene_quads++;
      if (batch_count >= batch_limit || (kind == KIND_TEXTURED && slots_in_use >= SLOTS))
        close_batch(r);
    end else if (kind == KIND_END) begin
      if (batch_count > 0 || slots_in_use > 1) close_batch(r);
    end
    r.quad_total    = scene_quads[SQ_W-1:0];
    r.draw_total    = scene_draws[SD_W-1:0];
    r.texture_total = scene_textures[ST_W-1:0];
    if (kind == KIND_END) begin
      scene_quads    = 0;
      scene_draws    = 0;
      scene_textures = 1;
    end
    return r;
  endfunction

  function automatic logic [TID_W-1:0] pick_handle();
    case ($urandom_range(9))
      0:       return white_handle;
      1, 2:    return $urandom();
      default: return handle_pool[$urandom_range(POOL_N - 1)];
    endcase
  endfunction

  // result side: ready pattern plus long hold-offs on request
  always @(posedge clk) begin : sink_drive
    int hold_seen;
    int hold_left;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk) begin : res_check
    draw_result_t got;
    draw_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.slot          = res_if.slot;
      got.flushed       = res_if.flushed;
      got.flush_quads   = res_if.flush_quads;
      got.flush_slots   = res_if.flush_slots;
      got.quad_total    = res_if.scene_quad_total;
      got.draw_total    = res_if.scene_draw_total;
      got.texture_total = res_if.scene_texture_total;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: slot %0d flushed %0d", got.slot, got.flushed);
      end else begin
        want = pending_results.pop_front();
        if (got.slot !== want.slot || got.flushed !== want.flushed ||
            got.flush_quads !== want.flush_quads || got.flush_slots !== want.flush_slots ||
            got.quad_total !== want.quad_total || got.draw_total !== want.draw_total ||
            got.texture_total !== want.texture_total) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t: exp slot %0d fl %0d fq %0d fs %0d q %0d d %0d t %0d",
                     $realtime, want.slot, want.flushed, want.flush_quads, want.flush_slots,
                     want.quad_total, want.draw_total, want.texture_total);
            $display("  got slot %0d fl %0d fq %0d fs %0d q %0d d %0d t %0d",
                     got.slot, got.flushed, got.flush_quads, got.flush_slots,
                     got.quad_total, got.draw_total, got.texture_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_draw(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] tid);
    while ($urandom_range(99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.texture_id <= tid;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(predict_draw(kind, tid));
  endtask

  task automatic send_random_draw();
    int pick;
    pick = $urandom_range(99);
    if (pick < 38)      send_draw(KIND_PLAIN, $urandom());
    else if (pick < 86) send_draw(KIND_TEXTURED, pick_handle());
    else if (pick < 97) send_draw(KIND_END, $urandom());
    else                send_draw(KIND_RSVD, $urandom());
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MAX_QUADS) batch_limit = data[QUAD_W-1:0];
    else if (idx == CFG_WHITE_ID) white_handle = data[TID_W-1:0];
  endtask

  task automatic set_batch_limit(input int value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom();
    word[QUAD_W-1:0] = value[QUAD_W-1:0];
    cfg_write(CFG_MAX_QUADS, word);
  endtask

  task automatic shuffle_config();
    case ($urandom_range(6))
      0:       set_batch_limit(0);
      1:       set_batch_limit(1);
      2:       set_batch_limit(QUAD_MAX);
      3:       set_batch_limit($urandom_range(2, 6));
      default: set_batch_limit($urandom_range(1, 40));
    endcase
    if ($urandom_range(1)) cfg_write(CFG_WHITE_ID, pick_handle());
  endtask

  task automatic test_white_handle();
    send_draw(KIND_TEXTURED, 32'h0000_0000);
    send_draw(KIND_TEXTURED, 32'hFFFF_FFFF);
    send_draw(KIND_RSVD, 32'h1234_5678);
    send_draw(KIND_END, 32'h0);
    send_draw(KIND_END, 32'hFFFF_FFFF);
  endtask

  task automatic test_batch_limit();
    cfg_write(CFG_WHITE_ID, 32'hA5A5_5A5A);
    set_batch_limit(3);
    send_draw(KIND_TEXTURED, 32'hA5A5_5A5A);
    send_draw(KIND_TEXTURED, 32'h0000_0000);
    send_draw(KIND_PLAIN, $urandom());
    set_batch_limit(0);
    send_draw(KIND_PLAIN, $urandom());
    send_draw(KIND_TEXTURED, 32'h5A5A_A5A5);
    // limit lowered below the open count
    set_batch_limit(20);
    send_draw(KIND_PLAIN, $urandom());
    send_draw(KIND_PLAIN, $urandom());
    set_batch_limit(1);
    send_draw(KIND_PLAIN, $urandom());
  endtask

  task automatic test_slot_fill();
    logic [3:0] nib;
    set_batch_limit(QUAD_MAX);
    cfg_write(CFG_WHITE_ID, 32'hFFFF_FFFF);
    for (int i = 1; i <= 3; i++) begin
      nib = i[3:0];
      send_draw(KIND_TEXTURED, {8{nib}});
    end
    // white moved onto a handle already held in an open slot
    cfg_write(CFG_WHITE_ID, 32'h2222_2222);
    send_draw(KIND_TEXTURED, 32'h2222_2222);
    send_draw(KIND_TEXTURED, 32'h3333_3333);
    for (int i = 4; i <= 14; i++) begin
      nib = i[3:0];
      send_draw(KIND_TEXTURED, {8{nib}});
    end
    send_draw(KIND_TEXTURED, 32'hFFFF_FFFF);
    send_draw(KIND_END, 32'h0);
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    src_idle   = idle;
    sink_stall = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 110 == 0) shuffle_config();
      send_random_draw();
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    src_idle   = 0;
    sink_stall = 0;
    hold_len   = 300;
    hold_seq++;
    repeat (40) send_random_draw();
    wait_idle();
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_index           = CFG_MAX_QUADS;
    cfg_data            = '0;
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_PLAIN;
    req_if.texture_id   = '0;
    res_if.ready        = 1'b0;
    src_idle            = 0;
    sink_stall          = 0;
    hold_len            = 0;
    hold_seq            = 0;
    mismatches          = 0;
    quiet_cycles        = 0;
    batch_limit         = MAX_QUADS_RESET;
    white_handle        = '0;
    slots_in_use        = 1;
    batch_count         = 0;
    scene_quads         = 0;
    scene_draws         = 0;
    scene_textures      = 1;
    foreach (slot_handles[i]) slot_handles[i] = '0;
    handle_pool[0] = 32'h0000_0000;
    handle_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_N; i++) handle_pool[i] = $urandom();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_white_handle();
    test_batch_limit();
    test_slot_fill();
    test_random_traffic(0, 0, 440);
    test_random_traffic(67, 0, 440);
    test_random_traffic(0, 67, 440);
    test_random_traffic(36, 36, 440);
    test_backpressure();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tsb_pkg.sv
rtl/core/tsb_ifs.sv
rtl/core/tsb_slot_table.sv
rtl/core/tsb_batch_stats.sv
rtl/core/texture_slot_batcher.sv
rtl/core/tsb_checker.sv
dv/tb_top.sv
